// ----- design/clil_pkg.sv -----
`timescale 1ns / 1ps
package clil_pkg;

	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_QUERY  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_ORDER = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]         func;
		logic [31:0]        time_value;
		logic signed [31:0] upper_value;
		logic signed [31:0] lower_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] upper_error;
		logic signed [31:0] lower_error;
	} out_item_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_SRCH,
		BK_SRCH_WAIT,
		BK_RD_HI,
		BK_RD_HI_WAIT,
		BK_RD_LO,
		BK_RD_LO_WAIT,
		BK_MUL,
		BK_DIV,
		BK_FIX,
		BK_OUT
	} bk_state_t;

	localparam int FIFO_DEPTH = 2;

endpackage

// ----- design/clil_front.sv -----
`timescale 1ns / 1ps
// Front: accept items and hand them to a short queue.
module clil_front import clil_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     q_valid,
	input  logic     q_ready,
	output in_item_t q_data
);
	in_item_t   mem_q [FIFO_DEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'(FIFO_DEPTH));
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(FIFO_DEPTH)) else $error("queue count overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'(FIFO_DEPTH)) |-> !push) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");

endmodule

// ----- design/clil_back.sv -----
`timescale 1ns / 1ps
// Back: table store, binary search, serial interpolation.
module clil_back import clil_pkg::*; #(
	parameter int AW = 6,
	parameter int DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_ready,
	input  in_item_t  q_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	localparam int CW = AW + 1;

	logic [31:0] time_mem [DEPTH];
	logic [31:0] up_mem   [DEPTH];
	logic [31:0] lo_mem   [DEPTH];

	bk_state_t   state_q, state_d;
	logic [CW-1:0] count_q;
	logic [31:0] last_time_q;
	in_item_t    item_q;
	logic [CW-1:0] lo_idx_q, hi_idx_q;
	logic [AW-1:0] rd_addr;
	logic [31:0] rd_t_q, rd_u_q, rd_l_q;
	logic [31:0] t1_q, u1_q, l1_q;
	logic [31:0] den_q;
	logic [63:0] pu_q, pl_q;
	logic        nu_q, nl_q;
	logic [63:0] ru_q, rl_q;
	logic [31:0] qu_q, ql_q;
	logic [5:0]  bit_q;
	out_item_t   res_q;
	logic        res_v_q;
	logic [CW-1:0] mid;
	logic signed [32:0] du, dl;
	logic [64:0] tu, tl;

	assign q_ready   = (state_q == BK_IDLE) && !res_v_q;
	assign out_valid = res_v_q;
	assign out_data  = res_q;
	assign mid = CW'((lo_idx_q + hi_idx_q) >> 1);

	always_comb begin
		unique case (state_q)
			BK_RD_HI, BK_RD_HI_WAIT: rd_addr = AW'(hi_idx_q);
			BK_RD_LO, BK_RD_LO_WAIT: rd_addr = AW'(hi_idx_q - CW'(1));
			default:                 rd_addr = AW'(mid);
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && q_valid && q_ready && q_data.func == FUNC_APPEND &&
		    count_q < CW'(DEPTH) && (count_q == '0 || q_data.time_value > last_time_q)) begin
			time_mem[AW'(count_q)] <= q_data.time_value;
			up_mem[AW'(count_q)]   <= q_data.upper_value;
			lo_mem[AW'(count_q)]   <= q_data.lower_value;
		end
		rd_t_q <= time_mem[rd_addr];
		rd_u_q <= up_mem[rd_addr];
		rd_l_q <= lo_mem[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:       if (q_valid && q_ready && q_data.func == FUNC_QUERY &&
			                   count_q != '0) state_d = BK_SRCH;
			BK_SRCH:       state_d = (lo_idx_q < hi_idx_q) ? BK_SRCH_WAIT : BK_RD_HI;
			BK_SRCH_WAIT:  state_d = BK_SRCH;
			BK_RD_HI:      state_d = BK_RD_HI_WAIT;
			BK_RD_HI_WAIT: state_d = BK_RD_LO;
			BK_RD_LO:      state_d = BK_RD_LO_WAIT;
			// exact hit or clamp skips the divider
			BK_RD_LO_WAIT: state_d = (t1_q == item_q.time_value || hi_idx_q == '0 ||
			                   t1_q < item_q.time_value) ? BK_OUT : BK_MUL;
			BK_MUL:        state_d = BK_DIV;
			BK_DIV:        state_d = (bit_q == 6'd0) ? BK_FIX : BK_DIV;
			BK_FIX:        state_d = BK_OUT;
			BK_OUT:        if (!res_v_q) state_d = BK_IDLE;
			default:       state_d = BK_IDLE;
		endcase
	end

	// Difference widened to 33 bits; magnitude fits 32 bits unsigned.
	assign du = 33'(signed'(u1_q)) - 33'(signed'(rd_u_q));
	assign dl = 33'(signed'(l1_q)) - 33'(signed'(rd_l_q));
	assign tu = {ru_q, pu_q[63]} - {33'd0, den_q};
	assign tl = {rl_q, pl_q[63]} - {33'd0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			count_q     <= '0;
			last_time_q <= '0;
			res_v_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_v_q && out_ready) res_v_q <= 1'b0;
			if (state_q == BK_IDLE && q_valid && q_ready) begin
				item_q <= q_data;
				res_q.upper_error <= '0;
				res_q.lower_error <= '0;
				unique case (func_t'(q_data.func))
					FUNC_CLEAR: begin
						res_q.status <= ST_OK;
						count_q <= '0;
						res_v_q <= 1'b1;
					end
					FUNC_APPEND: begin
						res_v_q <= 1'b1;
						if (count_q >= CW'(DEPTH)) begin
							res_q.status <= ST_FULL;
						end else if (count_q != '0 && q_data.time_value <= last_time_q) begin
							res_q.status <= ST_ORDER;
						end else begin
							res_q.status <= ST_OK;
							count_q     <= count_q + CW'(1);
							last_time_q <= q_data.time_value;
						end
					end
					FUNC_QUERY: begin
						lo_idx_q <= '0;
						hi_idx_q <= count_q;
						if (count_q == '0) begin
							res_q.status <= ST_EMPTY;
							res_v_q <= 1'b1;
						end else begin
							res_q.status <= ST_OK;
						end
					end
					default: begin
						res_q.status <= ST_OK;
						res_v_q <= 1'b1;
					end
				endcase
			end
			if (state_q == BK_SRCH_WAIT) begin
				// first index with time >= query lies in [lo, hi]
				if (rd_t_q < item_q.time_value) lo_idx_q <= mid + CW'(1);
				else hi_idx_q <= mid;
			end
			if (state_q == BK_SRCH && !(lo_idx_q < hi_idx_q)) begin
				if (hi_idx_q == count_q) hi_idx_q <= count_q - CW'(1);
			end
			if (state_q == BK_RD_HI_WAIT) begin
				t1_q <= rd_t_q;
				u1_q <= rd_u_q;
				l1_q <= rd_l_q;
			end
			if (state_q == BK_RD_LO_WAIT) begin
				// hi index now clamped; exact, clamp or interpolate
				if (t1_q == item_q.time_value || hi_idx_q == '0 ||
				    t1_q < item_q.time_value) begin
					res_q.upper_error <= u1_q;
					res_q.lower_error <= l1_q;
					res_v_q <= 1'b1;
				end
			end
			if (state_q == BK_MUL) begin
				den_q <= t1_q - rd_t_q;
				nu_q  <= du[32];
				nl_q  <= dl[32];
				pu_q  <= (du[32] ? 32'(-du) : du[31:0]) * (item_q.time_value - rd_t_q);
				pl_q  <= (dl[32] ? 32'(-dl) : dl[31:0]) * (item_q.time_value - rd_t_q);
				ru_q  <= '0;
				rl_q  <= '0;
				bit_q <= 6'd63;
				qu_q  <= rd_u_q;
				ql_q  <= rd_l_q;
			end
			if (state_q == BK_DIV) begin
				bit_q <= bit_q - 6'd1;
				pu_q  <= {pu_q[62:0], !tu[64]};
				pl_q  <= {pl_q[62:0], !tl[64]};
				ru_q  <= tu[64] ? {ru_q[62:0], pu_q[63]} : tu[63:0];
				rl_q  <= tl[64] ? {rl_q[62:0], pl_q[63]} : tl[63:0];
			end
			if (state_q == BK_FIX) begin
				res_q.upper_error <= nu_q ?
					qu_q - pu_q[31:0] - 32'(ru_q != '0) : qu_q + pu_q[31:0];
				res_q.lower_error <= nl_q ?
					ql_q - pl_q[31:0] - 32'(rl_q != '0) : ql_q + pl_q[31:0];
				res_v_q <= 1'b1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("count beyond depth");
	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SRCH) |-> (lo_idx_q <= hi_idx_q && hi_idx_q <= count_q))
		else $error("search window broken");
	a_take_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |-> (state_q == BK_IDLE)) else $error("item taken while busy");

endmodule

// ----- design/clamped_linear_interp_lookup.sv -----
`timescale 1ns / 1ps
// Breakpoint table with clamped linear interpolation. Items (clear, append, query)
// enter a two-entry queue and are executed one at a time by the back end. Clear,
// append and ignored codes are answered directly. A query on a non-empty
// table runs a binary search over the table memory (up to log2(TABLE_DEPTH)+1
// probes), two reads of the neighbor points, one multiply and a 64-step restoring
// divider; an exact hit or a clamp skips the multiply and the divider. The result
// sits in an output register; the queue keeps accepting while it waits to be
// transferred. TABLE_DEPTH must be a power of two.
module clamped_linear_interp_lookup import clil_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	localparam int AW = $clog2(TABLE_DEPTH);

	logic     q_valid, q_ready;
	in_item_t q_data;

	// hold queued transfers between front and back
	clil_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.q_valid, .q_ready, .q_data
	);

	clil_back #(.AW(AW), .DEPTH(TABLE_DEPTH)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_data,
		.out_valid, .out_ready, .out_data
	);

endmodule
